FILE: rtl/tcse_pkg.sv
// shared types and constants of the text console cursor and scroll engine
// no dependencies; used by the channel interfaces and the top level
package tcse_pkg;

    // field widths of the request and result beats
    localparam int REQ_TYPE_W = 3;
    localparam int BYTE_W     = 8;
    localparam int CELL_W     = 16;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_LOC_W  = 11;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // register port
    localparam int   APB_ADDR_W     = 3;
    localparam int   APB_DATA_W     = 32;
    localparam logic REG_TEXT_COLOR = 1'b0;

    // character codes and cell values
    localparam logic [BYTE_W-1:0] CH_BACKSPACE     = 8'h08;
    localparam logic [BYTE_W-1:0] CH_NEWLINE       = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BLANK         = 8'h20;
    localparam logic [BYTE_W-1:0] TEXT_COLOR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL       = {TEXT_COLOR_RESET, CH_BLANK};

    // request codes
    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_PUT_CHAR   = 3'd0,
        REQ_WRITE_CELL = 3'd1,
        REQ_SET_CURSOR = 3'd2,
        REQ_SCROLL     = 3'd3,
        REQ_READ_CELL  = 3'd4
    } req_code_t;

endpackage

FILE: rtl/tcse_if.sv
// request and result channels of the console engine, valid/ready handshake
// depends on tcse_pkg for field widths
interface tcse_req_if;
    import tcse_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [BYTE_W-1:0]     char_code;
    logic [BYTE_W-1:0]     cell_color;
    logic [BYTE_W-1:0]     col;
    logic [BYTE_W-1:0]     row;
    logic [BYTE_W-1:0]     scroll_rows;

    modport source (
        output valid, req_type, char_code, cell_color, col, row, scroll_rows,
        input  ready
    );
    modport sink (
        input  valid, req_type, char_code, cell_color, col, row, scroll_rows,
        output ready
    );
endinterface

interface tcse_rsp_if;
    import tcse_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    read_data;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_col;
    logic [OUT_LOC_W-1:0] cursor_pos;
    logic                 bounds_error;

    modport source (
        output valid, read_data, cursor_row, cursor_col, cursor_pos, bounds_error,
        input  ready
    );
    modport sink (
        input  valid, read_data, cursor_row, cursor_col, cursor_pos, bounds_error,
        output ready
    );
endinterface

FILE: rtl/text_console_cursor_scroll_engine.sv
// text console engine: cell store, cursor, print, scroll and cell access
// depends on tcse_pkg and the channel interfaces in tcse_if.sv
//
// The engine holds ROWS x COLUMNS 16-bit cells (character in the low byte,
// attribute in the high byte) in one single-port-write, registered-read
// memory, plus a text cursor. After reset it runs a clearing pass over every
// cell that fills the store with blanks in white on black; no request beat
// is accepted until it ends, register writes are taken throughout. One
// request is worked at a time: a plain request (print, write, set cursor,
// read, or a zero-row scroll) passes the execute state, which does any
// store write or read, and the done state, which loads the result into the
// result register; no new beat is accepted before that load. A scroll, and
// a print or newline that runs off the bottom line, walks the whole store
// once through the memory port, one cell a cycle, in the scroll and tail
// states before the done state. The next request beat is taken while the
// previous result still waits in the output register; a result that finds
// the register still full holds the engine until the sink takes the old
// beat. Positions off the screen for write, read and set cursor change
// nothing and raise bounds_error. Every result beat carries the cursor
// after the request and its linear location row*COLUMNS+col.
module text_console_cursor_scroll_engine #(
    parameter int COLUMNS = tcse_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcse_pkg::ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tcse_req_if.sink                        req,
    tcse_rsp_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcse_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tcse_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcse_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import tcse_pkg::*;

    // store geometry
    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SRC_W  = $clog2(2 * CELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLUMNS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_TAIL,
        ST_DONE
    } state_t;

    state_t state_reg;

    // cursor and register
    logic [RW-1:0]     cur_row_reg;
    logic [CW-1:0]     cur_col_reg;
    logic [BYTE_W-1:0] text_color_reg;

    // request held for the work cycles
    logic [REQ_TYPE_W-1:0] op_reg;
    logic [BYTE_W-1:0]     char_reg;
    logic [BYTE_W-1:0]     attr_reg;
    logic [BYTE_W-1:0]     nrows_reg;
    logic                  off_reg;
    logic [ADDR_W-1:0]     addr_reg;

    // cursor position taken from every accepted beat for a set-cursor request, kept in its own registers
    logic [RW-1:0] set_row_reg;
    logic [CW-1:0] set_col_reg;

    // sweep counter, shared by the clearing pass and the scroll walk
    logic [ADDR_W-1:0] idx_reg;
    logic [SRC_W-1:0]  shift_reg;

    // pending scroll write, issued in the cycle after its read
    logic              wb_pend_reg;
    logic              wb_copy_reg;
    logic [ADDR_W-1:0] wb_addr_reg;

    // result register
    logic                 out_valid_reg;
    logic [CELL_W-1:0]    out_data_reg;
    logic [OUT_ROW_W-1:0] out_row_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic [OUT_LOC_W-1:0] out_loc_reg;
    logic                 out_err_reg;

    // cell store
    logic [CELL_W-1:0] cell_mem [CELLS];
    logic [CELL_W-1:0] mem_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [CELL_W-1:0] blank;
    assign blank = {text_color_reg, CH_BLANK};

    // ---------------------------------------------------------------------
    // acceptance: pick the cell address while the beat is on the port
    // ---------------------------------------------------------------------
    logic              acc_put;
    logic              acc_off;
    logic [RW-1:0]     acc_row;
    logic [CW-1:0]     acc_col;
    logic [ADDR_W-1:0] acc_addr;
    logic              cfg_write;

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        acc_put = (req.req_type == REQ_PUT_CHAR);
        acc_off = (32'(req.col) >= COLUMNS) || (32'(req.row) >= ROWS);
        acc_row = acc_put ? cur_row_reg : req.row[RW-1:0];
        if (!acc_put)
            acc_col = req.col[CW-1:0];
        else if (req.char_code == CH_BACKSPACE)
            acc_col = cur_col_reg - CW'(1);
        else
            acc_col = cur_col_reg;
        // out-of-range addresses are never used, so truncation is harmless
        acc_addr = ADDR_W'(32'(acc_row) * COLUMNS + 32'(acc_col));
    end

    assign cfg_write = psel && penable && pwrite
                       && (paddr[APB_ADDR_W-1:2] == REG_TEXT_COLOR);
    assign pready    = 1'b1;
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_TEXT_COLOR)
                       ? {{(APB_DATA_W-BYTE_W){1'b0}}, text_color_reg} : '0;

    // ---------------------------------------------------------------------
    // execute decisions
    // ---------------------------------------------------------------------
    logic              is_bs;
    logic              is_nl;
    logic              row_last;
    logic              col_last;
    logic              exec_write;
    logic [CELL_W-1:0] exec_wdata;
    logic              put_scroll;
    logic [SRC_W-1:0]  scroll_shift;
    logic [SRC_W-1:0]  scr_src;
    logic              scr_copy;
    logic              idx_last;

    always_comb
    begin
        is_bs    = (char_reg == CH_BACKSPACE);
        is_nl    = (char_reg == CH_NEWLINE);
        row_last = (32'(cur_row_reg) == ROWS - 1);
        col_last = (32'(cur_col_reg) == COLUMNS - 1);

        exec_write = 1'b0;
        exec_wdata = {attr_reg, char_reg};
        put_scroll = 1'b0;
        case (op_reg)
            REQ_PUT_CHAR:
            begin
                if (is_bs)
                begin
                    exec_write = (cur_col_reg != '0);
                    exec_wdata = blank;
                end
                else if (is_nl)
                begin
                    put_scroll = row_last;
                end
                else
                begin
                    exec_write = 1'b1;
                    exec_wdata = {text_color_reg, char_reg};
                    put_scroll = col_last && row_last;
                end
            end
            REQ_WRITE_CELL:
            begin
                exec_write = !off_reg;
            end
            default:
            begin
            end
        endcase

        // a scroll of the full height or more blanks everything
        if (32'(nrows_reg) >= ROWS)
            scroll_shift = SRC_W'(CELLS);
        else
            scroll_shift = SRC_W'(32'(nrows_reg) * COLUMNS);

        scr_src  = SRC_W'(idx_reg) + shift_reg;
        scr_copy = (32'(scr_src) < CELLS);
        idx_last = (32'(idx_reg) == CELLS - 1);
    end

    // ---------------------------------------------------------------------
    // memory port control
    // ---------------------------------------------------------------------
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = exec_wdata;
        mem_re    = 1'b0;
        mem_raddr = addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = RESET_CELL;
            end
            ST_EXEC:
            begin
                mem_we = exec_write;
                mem_re = (op_reg == REQ_READ_CELL) && !off_reg;
            end
            ST_SCROLL, ST_TAIL:
            begin
                // reads run ahead of writes, so a source is never overwritten early
                mem_re    = (state_reg == ST_SCROLL) && scr_copy;
                mem_raddr = scr_src[ADDR_W-1:0];
                mem_we    = wb_pend_reg;
                mem_waddr = wb_addr_reg;
                mem_wdata = wb_copy_reg ? mem_rdata : blank;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata <= cell_mem[mem_raddr];
    end

    // ---------------------------------------------------------------------
    // result payload
    // ---------------------------------------------------------------------
    logic [31:0] row_ext;
    logic [31:0] col_ext;
    logic [31:0] loc_ext;

    always_comb
    begin
        row_ext = 32'(cur_row_reg);
        col_ext = 32'(cur_col_reg);
        loc_ext = row_ext * COLUMNS + col_ext;
    end

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            text_color_reg <= TEXT_COLOR_RESET;
            op_reg         <= '0;
            char_reg       <= '0;
            attr_reg       <= '0;
            nrows_reg      <= '0;
            off_reg        <= 1'b0;
            addr_reg       <= '0;
            idx_reg        <= '0;
            shift_reg      <= '0;
            wb_pend_reg    <= 1'b0;
            wb_copy_reg    <= 1'b0;
            wb_addr_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_loc_reg    <= '0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                text_color_reg <= pwdata[BYTE_W-1:0];

            // the final step loads the register itself when it is free
            if (rsp.ready && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_CLEAR:
                begin
                    idx_reg <= idx_reg + ADDR_W'(1);
                    if (idx_last)
                        state_reg <= ST_IDLE;
                end

                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg    <= req.req_type;
                        char_reg  <= req.char_code;
                        attr_reg  <= req.cell_color;
                        nrows_reg <= req.scroll_rows;
                        off_reg   <= acc_off;
                        addr_reg  <= acc_addr;
                        state_reg <= ST_EXEC;
                    end
                end

                ST_EXEC:
                begin
                    idx_reg     <= '0;
                    wb_pend_reg <= 1'b0;
                    state_reg   <= ST_DONE;
                    case (op_reg)
                        REQ_PUT_CHAR:
                        begin
                            if (is_bs)
                            begin
                                if (cur_col_reg != '0)
                                    cur_col_reg <= cur_col_reg - CW'(1);
                            end
                            else if (is_nl || col_last)
                            begin
                                cur_col_reg <= '0;
                                if (!row_last)
                                    cur_row_reg <= cur_row_reg + RW'(1);
                            end
                            else
                            begin
                                cur_col_reg <= cur_col_reg + CW'(1);
                            end
                            // running off the bottom line scrolls by one row
                            if (put_scroll)
                            begin
                                shift_reg <= SRC_W'(COLUMNS);
                                state_reg <= ST_SCROLL;
                            end
                        end
                        REQ_SET_CURSOR:
                        begin
                            if (!off_reg)
                            begin
                                cur_row_reg <= set_row_reg;
                                cur_col_reg <= set_col_reg;
                            end
                        end
                        REQ_SCROLL:
                        begin
                            if (nrows_reg != '0)
                            begin
                                shift_reg <= scroll_shift;
                                state_reg <= ST_SCROLL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                ST_SCROLL:
                begin
                    wb_pend_reg <= 1'b1;
                    wb_copy_reg <= scr_copy;
                    wb_addr_reg <= idx_reg;
                    idx_reg     <= idx_reg + ADDR_W'(1);
                    if (idx_last)
                        state_reg <= ST_TAIL;
                end

                ST_TAIL:
                begin
                    wb_pend_reg <= 1'b0;
                    state_reg   <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= ((op_reg == REQ_READ_CELL) && !off_reg)
                                         ? mem_rdata : '0;
                        out_row_reg   <= row_ext[OUT_ROW_W-1:0];
                        out_col_reg   <= col_ext[OUT_COL_W-1:0];
                        out_loc_reg   <= loc_ext[OUT_LOC_W-1:0];
                        out_err_reg   <= off_reg && (op_reg inside
                                         {REQ_WRITE_CELL, REQ_SET_CURSOR, REQ_READ_CELL});
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_row_reg <= '0;
            set_col_reg <= '0;
        end
        else if (state_reg == ST_IDLE && req.valid)
        begin
            set_row_reg <= req.row[RW-1:0];
            set_col_reg <= req.col[CW-1:0];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_data_reg;
    assign rsp.cursor_row   = out_row_reg;
    assign rsp.cursor_col   = out_col_reg;
    assign rsp.cursor_pos   = out_loc_reg;
    assign rsp.bounds_error = out_err_reg;

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == ST_EXEC)
        else $error("accepted beat did not enter execute");

    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_row_reg) < ROWS && 32'(cur_col_reg) < COLUMNS)
        else $error("cursor left the screen");

    a_no_write_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE || state_reg == ST_DONE |-> !mem_we)
        else $error("store written outside a work cycle");

    a_scroll_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("read and write hit the same cell");

    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.bounds_error |-> rsp.read_data == '0)
        else $error("rejected request returned cell data");

endmodule

FILE: verif/tb_text_console_cursor_scroll_engine.sv
// testbench of the text console engine: printing, cell access, cursor and scrolls
// checks every result beat against a cycle-free image of the screen and cursor
// depends on tcse_pkg, tcse_if.sv and text_console_cursor_scroll_engine
module tb_text_console_cursor_scroll_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import tcse_pkg::*;

    // geometry of the instance, left at its defaults
    localparam int SCREEN_COLS  = COLUMNS_DEF;
    localparam int SCREEN_ROWS  = ROWS_DEF;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

    // a scroll walks the whole store, the clearing pass after reset does too;
    // the limit covers either several times over, plus the longest stalls
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PRINT_CAP      = 100;

    // request codes beyond the last operation, which change nothing
    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED_HI = 3'd7;

    // text colour register at byte address 4 * index
    localparam logic [APB_ADDR_W-1:0] TEXT_COLOR_ADDR = APB_ADDR_W'({REG_TEXT_COLOR, 2'b00});

    // printable bytes used in the directed part
    localparam logic [BYTE_W-1:0] CH_LETTER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_LETTER_B = 8'h42;

    // screen edges as byte-wide fields
    localparam logic [BYTE_W-1:0] COL_END   = BYTE_W'(SCREEN_COLS);
    localparam logic [BYTE_W-1:0] ROW_END   = BYTE_W'(SCREEN_ROWS);
    localparam logic [BYTE_W-1:0] COL_LAST  = BYTE_W'(SCREEN_COLS - 1);
    localparam logic [BYTE_W-1:0] ROW_LAST  = BYTE_W'(SCREEN_ROWS - 1);
    localparam logic [BYTE_W-1:0] COL_PREV  = BYTE_W'(SCREEN_COLS - 2);
    localparam logic [BYTE_W-1:0] ROW_PREV  = BYTE_W'(SCREEN_ROWS - 2);

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] kind;
        logic [BYTE_W-1:0]     char_code;
        logic [BYTE_W-1:0]     cell_color;
        logic [BYTE_W-1:0]     col;
        logic [BYTE_W-1:0]     row;
        logic [BYTE_W-1:0]     scroll_rows;
    } console_req_t;

    typedef struct packed {
        logic [CELL_W-1:0]    read_data;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [OUT_COL_W-1:0] cursor_col;
        logic [OUT_LOC_W-1:0] cursor_pos;
        logic                 bounds_error;
    } cursor_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tcse_req_if req_bus ();
    tcse_rsp_if rsp_bus ();

    text_console_cursor_scroll_engine i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus),
        .rsp     (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // screen image: what the store, the cursor and the colour hold after
    // every accepted request beat, updated in acceptance order
    // ------------------------------------------------------------------
    logic [CELL_W-1:0] screen_cells [SCREEN_CELLS];
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [BYTE_W-1:0] text_attr;

    cursor_report_t awaited_reports [$];

    int unsigned fault_count;
    int unsigned beats_checked;
    int unsigned colour_settings;
    int unsigned kind_count [8];
    int unsigned burst_left;

    function automatic void clear_screen_image();
        foreach (screen_cells[i])
            screen_cells[i] = RESET_CELL;
        cur_row   = 0;
        cur_col   = 0;
        text_attr = TEXT_COLOR_RESET;
    endfunction

    function automatic logic [CELL_W-1:0] blank_word();
        return {text_attr, CH_BLANK};
    endfunction

    // move the image up by n rows, filling the bottom with blanks
    function automatic void scroll_screen_image(int unsigned n);
        int unsigned shift;
        if (n == 0)
            return;
        if (n >= SCREEN_ROWS)
        begin
            foreach (screen_cells[i])
                screen_cells[i] = blank_word();
            return;
        end
        shift = n * SCREEN_COLS;
        for (int i = 0; i < SCREEN_CELLS - shift; i++)
            screen_cells[i] = screen_cells[i + shift];
        for (int i = SCREEN_CELLS - shift; i < SCREEN_CELLS; i++)
            screen_cells[i] = blank_word();
    endfunction

    function automatic void print_on_image(logic [BYTE_W-1:0] ch);
        if (ch == CH_BACKSPACE)
        begin
            // nothing at column zero, else step left and blank that cell
            if (cur_col > 0)
            begin
                cur_col--;
                screen_cells[cur_row * SCREEN_COLS + cur_col] = blank_word();
            end
        end
        else if (ch == CH_NEWLINE)
        begin
            if (cur_row >= SCREEN_ROWS - 1)
            begin
                scroll_screen_image(1);
                cur_row = SCREEN_ROWS - 1;
            end
            else
                cur_row++;
            cur_col = 0;
        end
        else
        begin
            screen_cells[cur_row * SCREEN_COLS + cur_col] = {text_attr, ch};
            cur_col++;
            if (cur_col >= SCREEN_COLS)
            begin
                // wrap, and past the last line the screen moves up one row
                cur_col = 0;
                cur_row++;
                if (cur_row >= SCREEN_ROWS)
                begin
                    scroll_screen_image(1);
                    cur_row = SCREEN_ROWS - 1;
                end
            end
        end
    endfunction

    // apply one request to the image and return the report it should cause
    function automatic cursor_report_t apply_to_screen(console_req_t item);
        cursor_report_t rep;
        logic           off_screen;
        int unsigned    idx;
        off_screen = (item.col >= SCREEN_COLS) || (item.row >= SCREEN_ROWS);
        idx = item.row * SCREEN_COLS + item.col;
        rep = '0;
        case (item.kind)
            REQ_PUT_CHAR:
                print_on_image(item.char_code);
            REQ_WRITE_CELL:
                if (off_screen)
                    rep.bounds_error = 1'b1;
                else
                    screen_cells[idx] = {item.cell_color, item.char_code};
            REQ_SET_CURSOR:
                if (off_screen)
                    rep.bounds_error = 1'b1;
                else
                begin
                    cur_row = item.row;
                    cur_col = item.col;
                end
            REQ_SCROLL:
                scroll_screen_image(item.scroll_rows);
            REQ_READ_CELL:
                if (off_screen)
                    rep.bounds_error = 1'b1;
                else
                    rep.read_data = screen_cells[idx];
            default:
                ;
        endcase
        rep.cursor_row = OUT_ROW_W'(cur_row);
        rep.cursor_col = OUT_COL_W'(cur_col);
        rep.cursor_pos = OUT_LOC_W'(cur_row * SCREEN_COLS + cur_col);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_fault(input string msg);
        fault_count++;
        // keep the log short when a broken build fails every beat
        if (fault_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [CELL_W-1:0] got,
                                 input logic [CELL_W-1:0] want);
        if (got !== want)
            report_fault($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                   beats_checked, name, got, want));
    endtask

    // each result beat is taken at the edge where valid and ready are both high;
    // both are sampled before that edge updates anything
    always @(posedge clk)
    begin : result_checker
        cursor_report_t want;
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (awaited_reports.size() == 0)
                report_fault("result beat with no request outstanding");
            else
            begin
                want = awaited_reports.pop_front();
                compare_field("read_data", rsp_bus.read_data, want.read_data);
                compare_field("cursor_row", CELL_W'(rsp_bus.cursor_row),
                              CELL_W'(want.cursor_row));
                compare_field("cursor_col", CELL_W'(rsp_bus.cursor_col),
                              CELL_W'(want.cursor_col));
                compare_field("cursor_pos", CELL_W'(rsp_bus.cursor_pos),
                              CELL_W'(want.cursor_pos));
                compare_field("bounds_error", CELL_W'(rsp_bus.bounds_error),
                              CELL_W'(want.bounds_error));
            end
            beats_checked++;
        end
    end

    // ------------------------------------------------------------------
    // result side: ready follows a pattern that changes every so often,
    // from always ready through alternate cycles to long stalls
    // ------------------------------------------------------------------
    initial
    begin : result_stalls
        int unsigned mode;
        int unsigned span;
        int unsigned hold;
        logic        level;
        hold  = 0;
        level = 1'b1;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: rsp_bus.ready <= 1'b1;
                    1: rsp_bus.ready <= !rsp_bus.ready;
                    2: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        // runs of stall and runs of ready of random length
                        if (hold == 0)
                        begin
                            level = !level;
                            hold  = level ? $urandom_range(1, 8) : $urandom_range(1, 12);
                        end
                        hold--;
                        rsp_bus.ready <= level;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when no beat moves on either channel for long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
                || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no beat for %0d cycles, %0d results outstanding",
                 $realtime, WATCHDOG_LIMIT, awaited_reports.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // request side and register port
    // ------------------------------------------------------------------
    function automatic console_req_t make_req(logic [REQ_TYPE_W-1:0] kind,
                                              logic [BYTE_W-1:0] ch,
                                              logic [BYTE_W-1:0] colour,
                                              logic [BYTE_W-1:0] c,
                                              logic [BYTE_W-1:0] r,
                                              logic [BYTE_W-1:0] n);
        return '{kind, ch, colour, c, r, n};
    endfunction

    // send one request beat; bursts of random length with random gaps between,
    // a quarter of the bursts follow the previous one with no gap at all
    task automatic send_request(input console_req_t item);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0)
            begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= item.kind;
        req_bus.char_code   <= item.char_code;
        req_bus.cell_color  <= item.cell_color;
        req_bus.col         <= item.col;
        req_bus.row         <= item.row;
        req_bus.scroll_rows <= item.scroll_rows;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        awaited_reports.push_back(apply_to_screen(item));
        kind_count[item.kind]++;
    endtask

    // drop valid and wait until every result is in and the engine is quiet
    task automatic settle_console();
        req_bus.valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register read: setup cycle, then the access cycle returns the data
    task automatic check_text_colour_reg(input logic [BYTE_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TEXT_COLOR_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata[BYTE_W-1:0] !== want)
            report_fault($sformatf("text colour register reads 0x%0h expected 0x%0h",
                                   prdata[BYTE_W-1:0], want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // register write, only while the engine is idle, then read it back
    task automatic write_text_colour(input logic [BYTE_W-1:0] colour);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TEXT_COLOR_ADDR;
        pwdata  <= APB_DATA_W'(colour);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        text_attr = colour;
        colour_settings++;
        check_text_colour_reg(colour);
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // the store comes out of its clearing pass as white-on-black blanks
    task automatic test_reset_contents();
        check_text_colour_reg(TEXT_COLOR_RESET);
        send_request(make_req(REQ_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0, 8'd0));
        send_request(make_req(REQ_READ_CELL, 8'hFF, 8'hFF, COL_LAST, ROW_LAST, 8'hFF));
    endtask

    // positions off the screen change nothing and raise bounds_error,
    // and the spare request codes leave everything alone
    task automatic test_off_screen();
        send_request(make_req(REQ_WRITE_CELL, 8'h55, 8'hAA, COL_END, 8'd0, 8'd0));
        send_request(make_req(REQ_READ_CELL, 8'h00, 8'h00, 8'd0, ROW_END, 8'd0));
        send_request(make_req(REQ_SET_CURSOR, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'd0));
        send_request(make_req(REQ_UNUSED_LO, 8'h41, 8'h00, 8'd3, 8'd3, 8'd30));
        send_request(make_req(REQ_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    // printing: backspace at and away from column zero, the extreme bytes,
    // wrap off the last cell and newline on the last row, both scrolling
    task automatic test_printing();
        send_request(make_req(REQ_SET_CURSOR, 8'h00, 8'h00, 8'd0, 8'd0, 8'd0));
        send_request(make_req(REQ_PUT_CHAR, CH_BACKSPACE, 8'h00, 8'd0, 8'd0, 8'd0));
        send_request(make_req(REQ_PUT_CHAR, 8'hFF, 8'h00, 8'd0, 8'd0, 8'd0));
        send_request(make_req(REQ_PUT_CHAR, 8'h00, 8'h00, 8'd0, 8'd0, 8'd0));
        send_request(make_req(REQ_PUT_CHAR, CH_BACKSPACE, 8'h00, 8'd0, 8'd0, 8'd0));
        send_request(make_req(REQ_READ_CELL, 8'h00, 8'h00, 8'd1, 8'd0, 8'd0));
        send_request(make_req(REQ_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0, 8'd0));
        send_request(make_req(REQ_SET_CURSOR, 8'h00, 8'h00, COL_PREV, ROW_LAST, 8'd0));
        send_request(make_req(REQ_PUT_CHAR, CH_LETTER_A, 8'h00, 8'd0, 8'd0, 8'd0));
        send_request(make_req(REQ_PUT_CHAR, CH_LETTER_B, 8'h00, 8'd0, 8'd0, 8'd0));
        send_request(make_req(REQ_READ_CELL, 8'h00, 8'h00, COL_PREV, ROW_PREV, 8'd0));
        send_request(make_req(REQ_PUT_CHAR, CH_NEWLINE, 8'h00, 8'd0, 8'd0, 8'd0));
    endtask

    // cell writes with the extreme bytes, then scrolls of none, one row,
    // the full height and the largest count
    task automatic test_cells_and_scroll();
        send_request(make_req(REQ_WRITE_CELL, 8'hFF, 8'hFF, COL_LAST, ROW_LAST, 8'd0));
        send_request(make_req(REQ_WRITE_CELL, 8'h00, 8'h00, 8'd0, 8'd0, 8'd0));
        send_request(make_req(REQ_SCROLL, 8'h00, 8'h00, 8'd0, 8'd0, 8'd0));
        send_request(make_req(REQ_SCROLL, 8'h00, 8'h00, 8'd0, 8'd0, 8'd1));
        send_request(make_req(REQ_READ_CELL, 8'h00, 8'h00, COL_LAST, ROW_PREV, 8'd0));
        send_request(make_req(REQ_SCROLL, 8'h00, 8'h00, 8'd0, 8'd0, ROW_END));
        send_request(make_req(REQ_SCROLL, 8'h00, 8'h00, 8'd0, 8'd0, 8'hFF));
        send_request(make_req(REQ_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0, 8'd0));
    endtask

    // ------------------------------------------------------------------
    // random traffic
    // ------------------------------------------------------------------

    // position for write, read and set cursor: mostly on screen, a share
    // near line ends and the bottom line to drive wraps and scrolls,
    // one in ten off the screen
    function automatic void place_item(inout console_req_t item);
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            item.col = BYTE_W'($urandom_range(SCREEN_COLS, 255));
            item.row = BYTE_W'($urandom);
        end
        else if (sel == 1)
        begin
            item.col = BYTE_W'($urandom);
            item.row = BYTE_W'($urandom_range(SCREEN_ROWS, 255));
        end
        else if (sel < 8)
        begin
            item.row = $urandom_range(0, 1) ? ROW_LAST : BYTE_W'(cur_row);
            item.col = BYTE_W'($urandom_range(SCREEN_COLS - 6, SCREEN_COLS - 1));
        end
        else
        begin
            item.row = BYTE_W'($urandom_range(0, SCREEN_ROWS - 1));
            item.col = BYTE_W'($urandom_range(0, SCREEN_COLS - 1));
        end
    endfunction

    // printed text: mostly printable bytes, with newlines, backspaces and
    // the odd arbitrary byte among them
    function automatic logic [BYTE_W-1:0] text_byte();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return CH_NEWLINE;
        if (sel < 13)
            return CH_BACKSPACE;
        if (sel < 18)
            return BYTE_W'($urandom);
        return BYTE_W'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic test_random_traffic(input logic [BYTE_W-1:0] colour,
                                       input int unsigned count);
        console_req_t item;
        int unsigned  pick;
        settle_console();
        write_text_colour(colour);
        for (int k = 0; k < count; k++)
        begin
            // fields the request does not use carry random noise
            item.kind        = REQ_TYPE_W'($urandom);
            item.char_code   = BYTE_W'($urandom);
            item.cell_color  = BYTE_W'($urandom);
            item.col         = BYTE_W'($urandom);
            item.row         = BYTE_W'($urandom);
            item.scroll_rows = BYTE_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 48)
            begin
                item.kind      = REQ_PUT_CHAR;
                item.char_code = text_byte();
            end
            else if (pick < 60)
            begin
                item.kind = REQ_WRITE_CELL;
                place_item(item);
            end
            else if (pick < 73)
            begin
                item.kind = REQ_READ_CELL;
                place_item(item);
            end
            else if (pick < 84)
            begin
                item.kind = REQ_SET_CURSOR;
                place_item(item);
            end
            else if (pick < 90)
            begin
                // scrolls of one row or more walk the store, so keep them to a few percent
                item.kind = REQ_SCROLL;
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    item.scroll_rows = BYTE_W'($urandom_range(0, 3));
                else if (pick < 9)
                    item.scroll_rows = BYTE_W'($urandom_range(4, SCREEN_ROWS - 1));
                else
                    item.scroll_rows = BYTE_W'($urandom_range(SCREEN_ROWS, 255));
            end
            else if (pick < 95)
                item.kind = REQ_TYPE_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            else
            begin
                item.kind      = REQ_PUT_CHAR;
                item.char_code = CH_NEWLINE;
            end
            send_request(item);
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned total;
        req_bus.valid       <= 1'b0;
        req_bus.req_type    <= REQ_PUT_CHAR;
        req_bus.char_code   <= '0;
        req_bus.cell_color  <= '0;
        req_bus.col         <= '0;
        req_bus.row         <= '0;
        req_bus.scroll_rows <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        fault_count     = 0;
        beats_checked   = 0;
        colour_settings = 0;
        burst_left      = 0;
        foreach (kind_count[i])
            kind_count[i] = 0;
        clear_screen_image();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // the first request beat waits out the clearing pass on its own
        test_reset_contents();
        test_off_screen();
        test_printing();
        test_cells_and_scroll();

        // random phases, each under its own text colour, extremes first
        test_random_traffic(8'hFF, 150);
        test_random_traffic(8'h00, 150);
        test_random_traffic(BYTE_W'($urandom_range(1, 254)), 150);
        test_random_traffic(BYTE_W'($urandom_range(1, 254)), 150);
        settle_console();

        if (awaited_reports.size() != 0)
            report_fault($sformatf("%0d results never arrived", awaited_reports.size()));

        total = 0;
        foreach (kind_count[i])
            total += kind_count[i];
        $display("covered %0d requests: %0d prints, %0d cell writes, %0d cursor moves,",
                 total, kind_count[REQ_PUT_CHAR], kind_count[REQ_WRITE_CELL],
                 kind_count[REQ_SET_CURSOR]);
        $display("  %0d scrolls, %0d reads, %0d spare codes; %0d results under %0d colours",
                 kind_count[REQ_SCROLL], kind_count[REQ_READ_CELL],
                 total - kind_count[REQ_PUT_CHAR] - kind_count[REQ_WRITE_CELL]
                 - kind_count[REQ_SET_CURSOR] - kind_count[REQ_SCROLL]
                 - kind_count[REQ_READ_CELL],
                 beats_checked, colour_settings + 1);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tcse_pkg.sv
rtl/tcse_if.sv
rtl/text_console_cursor_scroll_engine.sv
verif/tb_text_console_cursor_scroll_engine.sv
